### hw/rtl/rational_arithmetic_unit_assert.svh
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTH
// Clocked check, disabled while reset is asserted.
`define RAU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rational_arithmetic_unit: check failed");
// Clocked check that also holds during reset.
`define RAU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rational_arithmetic_unit: check failed");
`else
`define RAU_ASSERT(lbl, clk, rst_n, prop)
`define RAU_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hw/rtl/rau_pkg.sv
// Shared constants and controller/datapath interface types for the rational unit.
package rau_pkg;

    localparam int WIDTH_DEF = 32;

    // Operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DIV = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Multiplier product selects
    localparam logic [1:0] MSEL_T1 = 2'd0;
    localparam logic [1:0] MSEL_T2 = 2'd1;
    localparam logic [1:0] MSEL_DM = 2'd2;

    // Divider dividend / destination selects
    localparam logic DSEL_NUM = 1'b0;
    localparam logic DSEL_DEN = 1'b1;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       comb;
        logic       gcd_step;
        logic       gcd_fin;
        logic       div_start;
        logic       div_step;
        logic       div_save;
        logic       div_sel;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic zero;
        logic gcd_done;
        logic div_done;
        logic out_full;
    } t_sts;

endpackage

### hw/rtl/rau_controller.sv
// Sequencer for the rational unit: steps the datapath through one item at a time.
module rau_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rau_pkg::t_sts i_sts,
    output rau_pkg::t_cmd o_cmd
);
    import rau_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL0 = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_COMB = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_GCD  = 4'd6;
    localparam logic [3:0] S_DIVN = 4'd7;
    localparam logic [3:0] S_DIVD = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL0;
                end
            end
            S_MUL0: begin
                if (i_sts.err) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = MSEL_T1;
                    n_state       = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MSEL_T2;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MSEL_DM;
                n_state       = S_COMB;
            end
            S_COMB: begin
                o_cmd.comb = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                n_state = i_sts.zero ? S_FIN : S_GCD;
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    o_cmd.gcd_fin   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DSEL_NUM;
                    n_state         = S_DIVN;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIVN: begin
                if (i_sts.div_done) begin
                    o_cmd.div_save  = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DSEL_NUM;
                    n_state         = S_DIVD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DIVD: begin
                o_cmd.div_sel = DSEL_DEN;
                if (i_sts.div_done) begin
                    o_cmd.div_save = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FIN: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/rau_datapath.sv
// Datapath of the rational unit: magnitudes, shared multiplier, binary gcd, divider.
module rau_datapath #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [((4*WIDTH+2+7)/8)*8-1:0]        i_in_data,
    input  rau_pkg::t_cmd                         i_cmd,
    output rau_pkg::t_sts                         o_sts,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [((2*WIDTH+1+7)/8)*8-1:0]        o_out_data
);
    import rau_pkg::*;

    localparam int D       = 2 * WIDTH;
    localparam int KW      = $clog2(D);
    localparam int CW      = $clog2(D + 1);
    localparam int OUT_BITS = ((2*WIDTH+1+7)/8)*8;

    // Input unpack
    logic [1:0]       in_op;
    logic [WIDTH-1:0] in_an, in_ad, in_bn, in_bd;
    logic [WIDTH-1:0] mag_an, mag_ad, mag_bn, mag_bd;

    assign in_op = i_in_data[1:0];
    assign in_an = i_in_data[2 +: WIDTH];
    assign in_ad = i_in_data[2 + WIDTH +: WIDTH];
    assign in_bn = i_in_data[2 + 2*WIDTH +: WIDTH];
    assign in_bd = i_in_data[2 + 3*WIDTH +: WIDTH];

    // Magnitudes; the most negative value maps to 2^(WIDTH-1), which still fits
    assign mag_an = in_an[WIDTH-1] ? (~in_an + 1'b1) : in_an;
    assign mag_ad = in_ad[WIDTH-1] ? (~in_ad + 1'b1) : in_ad;
    assign mag_bn = in_bn[WIDTH-1] ? (~in_bn + 1'b1) : in_bn;
    assign mag_bd = in_bd[WIDTH-1] ? (~in_bd + 1'b1) : in_bd;

    logic [1:0]       r_op;
    logic             r_san, r_sad, r_sbn, r_sbd;
    logic [WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic             r_err, r_zero, r_neg;
    logic [D-1:0]     r_t1, r_t2, r_dm, r_nm;
    logic [D-1:0]     r_x, r_y, r_g;
    logic [KW-1:0]    r_k;
    logic [D:0]       r_rem;
    logic [D-1:0]     r_quo;
    logic [CW-1:0]    r_cnt;
    logic             r_out_valid;
    logic [OUT_BITS-1:0] r_out_data;

    // Shared multiplier operand select
    logic [WIDTH-1:0] mul_a, mul_b;
    logic [D-1:0]     prod;

    always_comb begin
        case (i_cmd.mul_sel)
            MSEL_T1: begin
                mul_a = r_an;
                mul_b = (r_op == OP_MUL) ? r_bn : r_bd;
            end
            MSEL_T2: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
            default: begin
                mul_a = r_ad;
                mul_b = (r_op == OP_DIV) ? r_bn : r_bd;
            end
        endcase
    end

    assign prod = D'(mul_a) * D'(mul_b);

    // Signed combine of the two cross products
    logic         s1, s2, addsub;
    logic [D-1:0] comb_nm;
    logic         comb_neg;

    assign s1     = r_san ^ r_sbd;
    assign s2     = (r_sbn ^ r_sad) ^ (r_op == OP_SUB);
    assign addsub = (r_op == OP_ADD) || (r_op == OP_SUB);

    always_comb begin
        if (addsub) begin
            if (s1 == s2) begin
                comb_nm  = r_t1 + r_t2;
                comb_neg = s1 ^ (r_sad ^ r_sbd);
            end else if (r_t1 >= r_t2) begin
                comb_nm  = r_t1 - r_t2;
                comb_neg = s1 ^ (r_sad ^ r_sbd);
            end else begin
                comb_nm  = r_t2 - r_t1;
                comb_neg = s2 ^ (r_sad ^ r_sbd);
            end
        end else begin
            comb_nm  = r_t1;
            comb_neg = (r_san ^ r_sad) ^ (r_sbn ^ r_sbd);
        end
    end

    // Restoring divider step
    logic [D:0] rem_sh;
    logic       rem_ge;

    assign rem_sh = {r_rem[D-1:0], r_quo[D-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_g});

    // Final result and range check
    logic [D-1:0]     lim;
    logic             ovf;
    logic [D-1:0]     neg_nm;
    logic [WIDTH-1:0] fin_num;
    logic [WIDTH-2:0] fin_den;
    logic [1:0]       fin_st;

    assign lim    = D'(1) << (WIDTH - 1);
    assign ovf    = (r_dm > (lim - 1'b1)) || (r_neg ? (r_nm > lim) : (r_nm > (lim - 1'b1)));
    assign neg_nm = ~r_nm + 1'b1;

    always_comb begin
        if (r_err) begin
            fin_num = '0;
            fin_den = (WIDTH-1)'(1);
            fin_st  = ST_ZERO_DIV;
        end else if (r_zero) begin
            fin_num = '0;
            fin_den = (WIDTH-1)'(1);
            fin_st  = ST_OK;
        end else if (ovf) begin
            fin_num = '0;
            fin_den = (WIDTH-1)'(1);
            fin_st  = ST_OVERFLOW;
        end else begin
            fin_num = r_neg ? neg_nm[WIDTH-1:0] : r_nm[WIDTH-1:0];
            fin_den = r_dm[WIDTH-2:0];
            fin_st  = ST_OK;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= in_op;
            r_san  <= in_an[WIDTH-1];
            r_sad  <= in_ad[WIDTH-1];
            r_sbn  <= in_bn[WIDTH-1];
            r_sbd  <= in_bd[WIDTH-1];
            r_an   <= mag_an;
            r_ad   <= mag_ad;
            r_bn   <= mag_bn;
            r_bd   <= mag_bd;
            r_err  <= (in_ad == '0) || (in_bd == '0) || ((in_op == OP_DIV) && (in_bn == '0));
            r_zero <= 1'b0;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MSEL_T1: r_t1 <= prod;
                MSEL_T2: r_t2 <= prod;
                default: r_dm <= prod;
            endcase
        end
        if (i_cmd.comb) begin
            r_nm   <= comb_nm;
            r_x    <= comb_nm;
            r_y    <= r_dm;
            r_k    <= '0;
            r_neg  <= comb_neg;
            r_zero <= (comb_nm == '0);
        end
        // Binary gcd step: strip common twos, then odd subtract
        if (i_cmd.gcd_step) begin
            if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x >= r_y) begin
                r_x <= r_x - r_y;
            end else begin
                r_y <= r_y - r_x;
            end
        end
        if (i_cmd.gcd_fin) begin
            r_g <= r_y << r_k;
        end
        // Divider save runs before a new start in the same cycle
        if (i_cmd.div_save) begin
            if (i_cmd.div_sel == DSEL_DEN) begin
                r_dm <= r_quo;
            end else begin
                r_nm <= r_quo;
            end
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= (i_cmd.div_save || (i_cmd.div_sel == DSEL_DEN)) ? r_dm : r_nm;
            r_cnt <= CW'(D);
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? (rem_sh - {1'b0, r_g}) : rem_sh;
            r_quo <= {r_quo[D-2:0], rem_ge};
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_data <= OUT_BITS'({fin_st, fin_den, fin_num});
        end
    end

    // Output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_sts.err      = r_err;
    assign o_sts.zero     = r_zero;
    assign o_sts.gcd_done = (r_x == '0);
    assign o_sts.div_done = (r_cnt == '0);
    assign o_sts.out_full = r_out_valid && !i_out_ready;

endmodule

### hw/rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: add, sub, mul, div of reduced fractions.
//
//  channel   direction  tdata fields (lsb first)
//  s_axis    in         operation[2], a_num, a_den, b_num, b_den, zero pad
//  m_axis    out        result_num, result_den[WIDTH-1], status[2], zero pad
//
// One item at a time: an accepted beat runs through the three shared multiplies,
// the combine, the binary gcd and the restoring divider before its result is
// loaded; the next beat can be taken in the cycle after the result is loaded.
// Error inputs go from the load straight to the result; a zero result skips the gcd and divider.
// Synchronous active-low reset clears control.
// A new beat is taken while the previous result waits in the output register.
module rational_arithmetic_unit #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // operation, a_num, a_den, b_num, b_den
    input  logic [((4*WIDTH+2+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // result_num, result_den, status
    output logic [((2*WIDTH+1+7)/8)*8-1:0]      o_m_axis_tdata
);
    import rau_pkg::*;

    `include "rational_arithmetic_unit_assert.svh"

    t_cmd cmd;
    t_sts sts;

    rau_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rau_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

    // Output fields seen by the checks
    logic [WIDTH-1:0] out_num;
    logic [WIDTH-2:0] out_den;
    logic [1:0]       out_st;
    logic             s_accept;

    assign out_num  = o_m_axis_tdata[WIDTH-1:0];
    assign out_den  = o_m_axis_tdata[2*WIDTH-2:WIDTH];
    assign out_st   = o_m_axis_tdata[2*WIDTH:2*WIDTH-1];
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    // Checks
    `RAU_ASSERT(a_busy_after_accept, i_clk, i_rst_n, s_accept |=> !o_s_axis_tready)
    `RAU_ASSERT(a_den_nonzero, i_clk, i_rst_n, o_m_axis_tvalid |-> (out_den != '0))
    `RAU_ASSERT(a_status_legal, i_clk, i_rst_n, o_m_axis_tvalid |-> (out_st != (ST_OVERFLOW | ST_ZERO_DIV)))
    `RAU_ASSERT(a_bad_is_zero, i_clk, i_rst_n, (o_m_axis_tvalid && (out_st != ST_OK)) |-> (out_num == '0))
    `RAU_ASSERT_ALWAYS(a_load_only_idle, i_clk, cmd.load |-> o_s_axis_tready)

endmodule
